>>> hdl/zmu_pkg.sv
package zmu_pkg;

  localparam int ADDR_W      = 16;
  localparam int ARENA_BYTES = 1 << ADDR_W;
  localparam int WORD_BYTES  = 16;
  localparam int WORD_W      = WORD_BYTES * 8;
  localparam int CNT_W       = $clog2(WORD_BYTES) + 1;
  localparam int PTR_W       = ADDR_W + 1;
  localparam int SUM_W       = ADDR_W + 2;
  localparam int DEPTH_W     = 13;
  localparam int DEPTH_MAX   = 4096;
  localparam int CFG_W       = 17;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ARENA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATIC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACK  = 2'd2;

  typedef enum logic [3:0] {
    ACT_INIT        = 4'd0,
    ACT_STATIC_LOAD = 4'd1,
    ACT_STATIC_STORE= 4'd2,
    ACT_PUSH        = 4'd3,
    ACT_POP         = 4'd4,
    ACT_PUSH_FRAME  = 4'd5,
    ACT_POP_FRAME   = 4'd6,
    ACT_ALLOC       = 4'd7,
    ACT_HEAP_RESET  = 4'd8,
    ACT_HEAP_LOAD   = 4'd9,
    ACT_HEAP_STORE  = 4'd10
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] byte_offset;
    logic [15:0] heap_base;
    logic [16:0] alloc_size;
    logic [63:0] write_lo;
    logic [63:0] write_hi;
    logic [31:0] return_addr;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] read_lo;
    logic [63:0] read_hi;
    logic [31:0] popped_return;
    logic [15:0] block_address;
    logic [12:0] depth_now;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

endpackage

>>> hdl/zmu_ram.sv
module zmu_ram (
  input  logic              clk,
  input  zmu_pkg::ram_req_t req,
  output logic [7:0]        rdata
);
  import zmu_pkg::*;

  logic [7:0] mem [ARENA_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

>>> hdl/vm_zoned_memory_unit.sv
// Zoned byte arena for a VM: static zone, stack and bump heap in one
// 64 KiB byte-wide synchronous RAM. One word in gives one result word out.
// Accesses move 16 bytes one per cycle through the single RAM port; loads
// and pops read each byte, stores and pushes write each byte, and
// bookkeeping actions (alloc, heap reset, failed checks) touch no RAM. A
// successful init clears the static zone one byte per cycle. in_stall stays
// high from accept until the result is loaded into the output register;
// config writes are only expected while idle.
module vm_zoned_memory_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [16:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  zmu_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output zmu_pkg::out_word_t           out_word
);
  import zmu_pkg::*;

  // config registers
  logic [CFG_W-1:0] arena_bytes, static_bytes, stack_bytes;

  // zone state
  logic [PTR_W-1:0]   static_top, stack_top, arena_end;
  logic [PTR_W-1:0]   stack_pointer, heap_pointer;
  logic [DEPTH_W-1:0] frame_depth;

  state_t state, state_next;

  // per-word working registers
  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0]  cnt;
  logic [PTR_W-1:0]  clr_cnt;
  logic [WORD_W-1:0] data;
  logic              res_ok, res_load, res_frame;
  logic [15:0]       res_block;

  ram_req_t   req;
  logic [7:0] rdata;

  zmu_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // decode of the incoming word against current bounds
  logic              accept;
  logic              d_ok, d_rd, d_wr, d_clr, d_frame;
  logic [ADDR_W-1:0] d_addr;
  logic [WORD_W-1:0] d_data;
  logic [SUM_W-1:0]  heap_addr, init_sum;

  assign accept    = in_valid && !in_stall;
  assign heap_addr = SUM_W'(in_word.heap_base) + SUM_W'(in_word.byte_offset);
  assign init_sum  = SUM_W'(static_bytes) + SUM_W'(stack_bytes);

  always_comb begin
    d_ok    = 1'b0;
    d_rd    = 1'b0;
    d_wr    = 1'b0;
    d_clr   = 1'b0;
    d_frame = 1'b0;
    d_addr  = '0;
    d_data  = {in_word.write_hi, in_word.write_lo};
    unique case (in_word.action)
      ACT_INIT: begin
        d_ok  = (arena_bytes != '0) && (SUM_W'(arena_bytes) <= SUM_W'(ARENA_BYTES))
                && (init_sum <= SUM_W'(arena_bytes));
        d_clr = d_ok && (static_bytes != '0);
      end
      ACT_STATIC_LOAD, ACT_STATIC_STORE: begin
        d_ok   = SUM_W'(in_word.byte_offset) + SUM_W'(WORD_BYTES) <= SUM_W'(static_top);
        d_addr = in_word.byte_offset;
        d_rd   = d_ok && (in_word.action == ACT_STATIC_LOAD);
        d_wr   = d_ok && (in_word.action == ACT_STATIC_STORE);
      end
      ACT_PUSH, ACT_PUSH_FRAME: begin
        d_ok   = SUM_W'(stack_pointer) + SUM_W'(WORD_BYTES) <= SUM_W'(stack_top);
        d_addr = stack_pointer[ADDR_W-1:0];
        d_wr   = d_ok;
        if (in_word.action == ACT_PUSH_FRAME) begin
          d_data = WORD_W'(in_word.return_addr);
        end
      end
      ACT_POP, ACT_POP_FRAME: begin
        d_frame = (in_word.action == ACT_POP_FRAME);
        d_ok    = !(d_frame && frame_depth == '0)
                  && (SUM_W'(stack_pointer) >= SUM_W'(static_top) + SUM_W'(WORD_BYTES));
        d_addr  = ADDR_W'(stack_pointer - PTR_W'(WORD_BYTES));
        d_rd    = d_ok;
      end
      ACT_ALLOC: begin
        d_ok = SUM_W'(heap_pointer) + SUM_W'(in_word.alloc_size) <= SUM_W'(arena_end);
      end
      ACT_HEAP_RESET: begin
        d_ok = 1'b1;
      end
      ACT_HEAP_LOAD, ACT_HEAP_STORE: begin
        d_ok   = (heap_addr >= SUM_W'(stack_top))
                 && (heap_addr + SUM_W'(WORD_BYTES) <= SUM_W'(arena_end));
        d_addr = heap_addr[ADDR_W-1:0];
        d_rd   = d_ok && (in_word.action == ACT_HEAP_LOAD);
        d_wr   = d_ok && (in_word.action == ACT_HEAP_STORE);
      end
      default: ;
    endcase
  end

  // next state and RAM request
  always_comb begin
    state_next = state;
    req.we     = 1'b0;
    req.addr   = base + ADDR_W'(cnt);
    req.wdata  = data[7:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (d_clr) state_next = ST_CLEAR;
          else if (d_rd)      state_next = ST_READ;
          else if (d_wr)      state_next = ST_WRITE;
          else                state_next = ST_DONE;
        end
      end
      ST_CLEAR: begin
        req.we    = 1'b1;
        req.addr  = clr_cnt[ADDR_W-1:0];
        req.wdata = '0;
        if (clr_cnt + PTR_W'(1) == static_top) state_next = ST_DONE;
      end
      ST_READ: begin
        if (cnt == CNT_W'(WORD_BYTES)) state_next = ST_DONE;
      end
      ST_WRITE: begin
        req.we = 1'b1;
        if (cnt == CNT_W'(WORD_BYTES - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      arena_bytes   <= CFG_W'(ARENA_BYTES);
      static_bytes  <= '0;
      stack_bytes   <= '0;
      static_top    <= '0;
      stack_top     <= '0;
      arena_end     <= '0;
      stack_pointer <= '0;
      heap_pointer  <= '0;
      frame_depth   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ARENA:  arena_bytes  <= cfg_data;
          REG_STATIC: static_bytes <= cfg_data;
          REG_STACK:  stack_bytes  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_DONE && state_next == ST_IDLE) out_valid <= 1'b1;

      // pointer bookkeeping happens at accept; a failed check changes nothing
      if (state == ST_IDLE && accept && d_ok) begin
        unique case (in_word.action)
          ACT_INIT: begin
            arena_end     <= arena_bytes;
            static_top    <= static_bytes;
            stack_top     <= PTR_W'(init_sum);
            stack_pointer <= static_bytes;
            heap_pointer  <= PTR_W'(init_sum);
            frame_depth   <= '0;
          end
          ACT_PUSH: stack_pointer <= stack_pointer + PTR_W'(WORD_BYTES);
          ACT_PUSH_FRAME: begin
            stack_pointer <= stack_pointer + PTR_W'(WORD_BYTES);
            if (frame_depth < DEPTH_W'(DEPTH_MAX)) frame_depth <= frame_depth + DEPTH_W'(1);
          end
          ACT_POP: stack_pointer <= stack_pointer - PTR_W'(WORD_BYTES);
          ACT_POP_FRAME: begin
            stack_pointer <= stack_pointer - PTR_W'(WORD_BYTES);
            frame_depth   <= frame_depth - DEPTH_W'(1);
          end
          ACT_ALLOC:      heap_pointer <= PTR_W'(SUM_W'(heap_pointer)
                                          + SUM_W'(in_word.alloc_size));
          ACT_HEAP_RESET: heap_pointer <= stack_top;
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cnt       <= '0;
        clr_cnt   <= '0;
        base      <= d_addr;
        data      <= d_data;
        res_ok    <= d_ok;
        res_load  <= d_rd && !d_frame;
        res_frame <= d_rd && d_frame;
        res_block <= (in_word.action == ACT_ALLOC && d_ok) ? heap_pointer[15:0] : '0;
      end
      ST_CLEAR: clr_cnt <= clr_cnt + PTR_W'(1);
      ST_READ: begin
        cnt <= cnt + CNT_W'(1);
        // byte n lands the cycle after its address; shift in from the top
        if (cnt != '0) data <= {rdata, data[WORD_W-1:8]};
      end
      ST_WRITE: begin
        cnt  <= cnt + CNT_W'(1);
        data <= data >> 8;
      end
      ST_DONE: begin
        if (state_next == ST_IDLE) begin
          out_word.ok            <= res_ok;
          out_word.read_lo       <= res_load ? data[63:0] : '0;
          out_word.read_hi       <= res_load ? data[127:64] : '0;
          out_word.popped_return <= res_frame ? data[31:0] : '0;
          out_word.block_address <= res_block;
          out_word.depth_now     <= frame_depth;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/zmu_checker.sv
module zmu_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input zmu_pkg::out_word_t out_word
);
  import zmu_pkg::*;

  // stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a second word while busy");

  // failed action returns no data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.ok |-> out_word.read_lo == '0 && out_word.read_hi == '0
      && out_word.popped_return == '0 && out_word.block_address == '0)
    else $error("failed action returned data");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.depth_now <= DEPTH_W'(DEPTH_MAX))
    else $error("call depth beyond saturation");

endmodule

bind vm_zoned_memory_unit zmu_checker u_zmu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

>>> tb/sv/zmu_checker.sv
`timescale 1ns / 1ps

module zmu_scoreboard (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [16:0]          cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  zmu_pkg::in_word_t    in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  zmu_pkg::out_word_t   out_word,
  output int                   errors,
  output int                   pending,
  output int                   checked
);
  import zmu_pkg::*;

  logic [7:0]  arena_mem [ARENA_BYTES];
  logic [16:0] r_arena, r_static, r_stack;
  logic [16:0] z_static_top, z_stack_lim, z_arena_end, z_sp, z_hp;
  logic [12:0] z_depth;
  out_word_t   result_q [$];

  function automatic logic [127:0] fetch_word(logic [17:0] a);
    logic [127:0]      v;
    logic [ADDR_W-1:0] idx;
    v = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      idx = ADDR_W'(a + 18'(i));
      v[8*i +: 8] = arena_mem[idx];
    end
    return v;
  endfunction

  task automatic put_word(logic [17:0] a, logic [127:0] v);
    logic [ADDR_W-1:0] idx;
    for (int i = 0; i < WORD_BYTES; i++) begin
      idx = ADDR_W'(a + 18'(i));
      arena_mem[idx] = v[8*i +: 8];
    end
  endtask

  task automatic predict_access(input in_word_t w, output out_word_t r);
    logic [17:0]  addr;
    logic [127:0] v;
    r = '0;
    addr = w.heap_base + w.byte_offset;
    case (w.action)
      ACT_INIT: begin
        if (r_arena != 0 && r_arena <= ARENA_BYTES &&
            {1'b0, r_static} + r_stack <= r_arena) begin
          z_arena_end  = r_arena;
          z_static_top = r_static;
          z_stack_lim  = r_static + r_stack;
          z_sp         = r_static;
          z_hp         = z_stack_lim;
          z_depth      = '0;
          for (int i = 0; i < r_static; i++) arena_mem[ADDR_W'(i)] = 8'h00;
          r.ok = 1'b1;
        end
      end
      ACT_STATIC_LOAD, ACT_STATIC_STORE: begin
        if ({2'b0, w.byte_offset} + WORD_BYTES <= z_static_top) begin
          if (w.action == ACT_STATIC_LOAD)
            {r.read_hi, r.read_lo} = fetch_word({2'b0, w.byte_offset});
          else put_word({2'b0, w.byte_offset}, {w.write_hi, w.write_lo});
          r.ok = 1'b1;
        end
      end
      ACT_PUSH, ACT_PUSH_FRAME: begin
        if ({1'b0, z_sp} + WORD_BYTES <= z_stack_lim) begin
          if (w.action == ACT_PUSH) put_word({1'b0, z_sp}, {w.write_hi, w.write_lo});
          else begin
            put_word({1'b0, z_sp}, {96'b0, w.return_addr});
            if (z_depth < DEPTH_MAX) z_depth = z_depth + 13'd1;
          end
          z_sp = z_sp + 17'(WORD_BYTES);
          r.ok = 1'b1;
        end
      end
      ACT_POP, ACT_POP_FRAME: begin
        if (!(w.action == ACT_POP_FRAME && z_depth == 0) &&
            {1'b0, z_sp} >= {1'b0, z_static_top} + WORD_BYTES) begin
          z_sp = z_sp - 17'(WORD_BYTES);
          v = fetch_word({1'b0, z_sp});
          if (w.action == ACT_POP) {r.read_hi, r.read_lo} = v;
          else begin
            r.popped_return = v[31:0];
            z_depth = z_depth - 13'd1;
          end
          r.ok = 1'b1;
        end
      end
      ACT_ALLOC: begin
        if ({1'b0, z_hp} + w.alloc_size <= z_arena_end) begin
          r.block_address = z_hp[15:0];
          z_hp = z_hp + w.alloc_size;
          r.ok = 1'b1;
        end
      end
      ACT_HEAP_RESET: begin
        z_hp = z_stack_lim;
        r.ok = 1'b1;
      end
      ACT_HEAP_LOAD, ACT_HEAP_STORE: begin
        if (addr >= z_stack_lim && addr + WORD_BYTES <= z_arena_end) begin
          if (w.action == ACT_HEAP_LOAD) {r.read_hi, r.read_lo} = fetch_word(addr);
          else put_word(addr, {w.write_hi, w.write_lo});
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.depth_now = z_depth;
  endtask

  always @(posedge clk) begin
    out_word_t got, want;
    if (rst) begin
      r_arena = 17'(ARENA_BYTES); r_static = '0; r_stack = '0;
      z_static_top = '0; z_stack_lim = '0; z_arena_end = '0;
      z_sp = '0; z_hp = '0; z_depth = '0;
      for (int i = 0; i < ARENA_BYTES; i++) arena_mem[ADDR_W'(i)] = 8'h00;
      result_q.delete();
      errors = 0; checked = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ARENA:  r_arena  = cfg_data;
          REG_STATIC: r_static = cfg_data;
          REG_STACK:  r_stack  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_word;
        checked++;
        if (result_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok exp %0h got %0h", want.ok, got.ok); errors++;
          end
          if (got.read_lo !== want.read_lo) begin
            $error("read_lo exp %0h got %0h", want.read_lo, got.read_lo); errors++;
          end
          if (got.read_hi !== want.read_hi) begin
            $error("read_hi exp %0h got %0h", want.read_hi, got.read_hi); errors++;
          end
          if (got.popped_return !== want.popped_return) begin
            $error("popped_return exp %0h got %0h", want.popped_return, got.popped_return);
            errors++;
          end
          if (got.block_address !== want.block_address) begin
            $error("block_address exp %0h got %0h", want.block_address, got.block_address);
            errors++;
          end
          if (got.depth_now !== want.depth_now) begin
            $error("depth_now exp %0d got %0d", want.depth_now, got.depth_now); errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_access(in_word, want);
        result_q.push_back(want);
      end
    end
    pending = result_q.size();
  end

endmodule

>>> tb/sv/tb_vm_zoned_memory_unit.sv
`timescale 1ns / 1ps

module tb_vm_zoned_memory_unit;
  import zmu_pkg::*;

  localparam int STALL_LIMIT = 400000;  // a full static clear leaves both channels silent
  localparam int HOLD_CYCLES = 300;
  localparam logic [3:0] ACT_SPARE = 4'd15;  // no action assigned

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_ARENA;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;

  int errors, pending, checked;
  int words_sent = 0;
  int phases = 0;
  int quiet_cnt;

  // stimulus shaping only: last written register values
  logic [16:0] c_arena = 17'd65536, c_static = '0, c_stack = '0;

  // receiver control
  logic quiet = 1'b0;     // no idling on either side
  logic hold_req = 1'b0;  // ask the receiver for one long hold-off
  logic held = 1'b0;
  int   hold_cnt = 0;

  always #2 clk = ~clk;

  vm_zoned_memory_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  zmu_scoreboard chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .errors(errors), .pending(pending), .checked(checked)
  );

  // Receiver: random stalls, plus one long counted hold-off so the block
  // backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !held) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES) held <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 6);
    end
  end

  // Watchdog: cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one word and hold it until accepted; then maybe idle a few cycles.
  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Wait for every result word, let the block settle, then write all registers.
  task automatic set_regs(input logic [16:0] a, input logic [16:0] s, input logic [16:0] k);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= REG_ARENA;  cfg_data <= a; @(posedge clk);
    cfg_index <= REG_STATIC; cfg_data <= s; @(posedge clk);
    cfg_index <= REG_STACK;  cfg_data <= k; @(posedge clk);
    cfg_write <= 1'b0;
    c_arena = a; c_static = s; c_stack = k;
    phases++;
  endtask

  function automatic in_word_t mk(input action_t a, input logic [15:0] ofs = '0,
                                  input logic [15:0] base = '0,
                                  input logic [16:0] sz = '0);
    in_word_t w;
    w.action      = a;
    w.byte_offset = ofs;
    w.heap_base   = base;
    w.alloc_size  = sz;
    w.write_lo    = {$urandom, $urandom};
    w.write_hi    = {$urandom, $urandom};
    w.return_addr = $urandom;
    return w;
  endfunction

  // Random word, mostly aimed at the live zones so accesses tend to succeed.
  function automatic in_word_t rand_word(input bit allow_init);
    in_word_t    w;
    int          p;
    logic [16:0] lim;
    w = mk(ACT_HEAP_RESET);
    p = $urandom_range(0, 99);
    lim = c_static + c_stack;
    if      (p < 2)  w.action = allow_init ? ACT_INIT : ACT_HEAP_RESET;
    else if (p < 12) w.action = ACT_STATIC_LOAD;
    else if (p < 22) w.action = ACT_STATIC_STORE;
    else if (p < 32) w.action = ACT_PUSH;
    else if (p < 41) w.action = ACT_POP;
    else if (p < 49) w.action = ACT_PUSH_FRAME;
    else if (p < 57) w.action = ACT_POP_FRAME;
    else if (p < 65) w.action = ACT_ALLOC;
    else if (p < 68) w.action = ACT_HEAP_RESET;
    else if (p < 81) w.action = ACT_HEAP_LOAD;
    else if (p < 95) w.action = ACT_HEAP_STORE;
    else             w.action = action_t'($urandom_range(11, 15));
    if ($urandom_range(0, 9) < 7 && c_static >= 16)
      w.byte_offset = 16'($urandom_range(0, c_static - 16));
    else
      w.byte_offset = 16'($urandom);
    if (w.action inside {ACT_HEAP_LOAD, ACT_HEAP_STORE} &&
        $urandom_range(0, 9) < 8 && lim < c_arena && c_arena <= ARENA_BYTES) begin
      w.heap_base   = 16'($urandom_range(lim, c_arena - 1));
      w.byte_offset = 16'($urandom_range(0, 32));
    end else begin
      w.heap_base = 16'($urandom);
    end
    w.alloc_size = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(0, 64)) : 17'($urandom);
    return w;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before any init: bounds are all zero
    send_word(mk(ACT_STATIC_LOAD));
    send_word(mk(ACT_POP));
    send_word(mk(ACT_POP_FRAME));
    send_word(mk(ACT_ALLOC, 16'd0, 16'd0, 17'd0));
    send_word(mk(ACT_ALLOC, 16'd0, 16'd0, 17'd5));
    send_word(mk(ACT_HEAP_RESET));
    send_word(mk(ACT_HEAP_LOAD, 16'hffff, 16'hffff));
    begin
      in_word_t w;
      w = mk(ACT_HEAP_RESET);
      w.action = ACT_SPARE;
      send_word(w);
    end

    // whole arena static: init clears every byte, so later reads see known data
    set_regs(17'd65536, 17'd65536, 17'd0);
    send_word(mk(ACT_INIT));
    send_word(mk(ACT_STATIC_STORE, 16'd65520));
    send_word(mk(ACT_STATIC_LOAD, 16'd65520));
    send_word(mk(ACT_STATIC_LOAD, 16'd65521));
    begin
      in_word_t w;
      w = mk(ACT_STATIC_STORE, 16'd0);
      w.write_lo = '1; w.write_hi = '1;
      send_word(w);
    end
    send_word(mk(ACT_STATIC_LOAD, 16'd0));
    send_word(mk(ACT_PUSH));
    send_word(mk(ACT_ALLOC, 16'd0, 16'd0, 17'd0));  // zero alloc at a full arena
    send_word(mk(ACT_HEAP_STORE, 16'd0, 16'hfff0));
    repeat (150) send_word(rand_word(1'b0));

    // general zones
    set_regs(17'd65536, 17'd256, 17'd1024);
    send_word(mk(ACT_INIT));
    send_word(mk(ACT_PUSH));
    send_word(mk(ACT_PUSH_FRAME));
    send_word(mk(ACT_POP_FRAME));
    send_word(mk(ACT_POP));
    send_word(mk(ACT_POP_FRAME));  // depth zero
    send_word(mk(ACT_ALLOC, 16'd0, 16'd0, 17'h1ffff));
    send_word(mk(ACT_HEAP_STORE, 16'd16, 16'd65504));
    send_word(mk(ACT_HEAP_LOAD, 16'd16, 16'd65504));
    send_word(mk(ACT_HEAP_RESET));
    for (int i = 0; i < 600; i++) begin
      if (i == 100) hold_req <= 1'b1;
      send_word(rand_word(1'b1));
    end

    // full-arena stack: a deep run of call frames, no idling
    quiet <= 1'b1;
    set_regs(17'd65536, 17'd0, 17'd65536);
    send_word(mk(ACT_INIT));
    repeat (300) send_word(mk(ACT_PUSH_FRAME));
    repeat (3) send_word(mk(ACT_POP_FRAME));
    send_word(mk(ACT_PUSH_FRAME));
    send_word(mk(ACT_ALLOC, 16'd0, 16'd0, 17'd1));
    quiet <= 1'b0;

    // init refusals keep the bounds already latched
    set_regs(17'd0, 17'd16, 17'd16);
    send_word(mk(ACT_INIT));
    set_regs(17'h1ffff, 17'd0, 17'd0);
    send_word(mk(ACT_INIT));
    set_regs(17'd1024, 17'd1000, 17'd100);
    send_word(mk(ACT_INIT));
    repeat (300) send_word(rand_word(1'b0));

    // small arena
    set_regs(17'd1000, 17'd16, 17'd512);
    send_word(mk(ACT_INIT));
    repeat (400) send_word(rand_word(1'b1));

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d input words, %0d results checked, %0d register settings",
             words_sent, checked, phases);
    $display("zones: pre-init, full static, mixed, deep call stack, refused inits, small arena");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
